/* sv/sign_magnitude_wide_adder_defines.svh */
// Assertion macros for the sign-magnitude wide adder checker.
// Depends on nothing; the checker file includes it.
`ifndef SIGN_MAGNITUDE_WIDE_ADDER_DEFINES_SVH
`define SIGN_MAGNITUDE_WIDE_ADDER_DEFINES_SVH

// Implication checked in the same cycle, suspended while reset is held.
`define SMA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked in the next cycle, suspended while reset is held.
`define SMA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// Implication checked in the next cycle, active during reset as well.
`define SMA_ASSERT_RST(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/sma_pkg.sv */
// Shared types and constants for the sign-magnitude wide adder.
// Used by sma_limb_unit and sign_magnitude_wide_adder; depends on nothing.
`timescale 1ns / 1ps

package sma_pkg;

    localparam int LIMB_W   = 64;
    localparam int IN_DW    = 264;
    localparam int OUT_DW   = 136;

    typedef logic [LIMB_W-1:0] limb_t;

    // Carry and borrow bits passed from one limb to the next.
    typedef struct packed {
        logic sum_c;   // carry of x + y
        logic ab_b;    // borrow of x - y
        logic ba_b;    // borrow of y - x
    } carry_t;

endpackage

/* sv/sma_limb_unit.sv */
// One 64-bit limb slice: the sum and both differences of two limbs.
// Depends on sma_pkg for limb_t and carry_t.
`timescale 1ns / 1ps

module sma_limb_unit
    import sma_pkg::*;
(
    input  limb_t  x,
    input  limb_t  y,
    input  carry_t cin,
    output limb_t  sum,
    output limb_t  dxy,
    output limb_t  dyx,
    output carry_t cout
);

    logic [LIMB_W:0] sum_w;
    logic [LIMB_W:0] dxy_w;
    logic [LIMB_W:0] dyx_w;

    // Sum with carry in, and both differences with their borrows in.
    always_comb begin
        sum_w = {1'b0, x} + {1'b0, y} + {{LIMB_W{1'b0}}, cin.sum_c};
        dxy_w = {1'b0, x} - {1'b0, y} - {{LIMB_W{1'b0}}, cin.ab_b};
        dyx_w = {1'b0, y} - {1'b0, x} - {{LIMB_W{1'b0}}, cin.ba_b};
    end

    // The top bit of each result is the carry or borrow out.
    assign sum        = sum_w[LIMB_W-1:0];
    assign dxy        = dxy_w[LIMB_W-1:0];
    assign dyx        = dyx_w[LIMB_W-1:0];
    assign cout.sum_c = sum_w[LIMB_W];
    assign cout.ab_b  = dxy_w[LIMB_W];
    assign cout.ba_b  = dyx_w[LIMB_W];

endmodule

/* sv/sign_magnitude_wide_adder.sv */
// Sign-magnitude adder for two 128-bit magnitudes with sign flags.
// Usage:
//   The s_ channel takes one operand pair per word; the m_ channel gives one
//   result word per operand pair, in the same order.
//   Sign flags are 1 for positive and 0 for negative. Equal signs add the
//   magnitudes and flag a carry out of 128 bits in status; different signs
//   subtract the smaller magnitude from the larger, and equal magnitudes give
//   a positive zero.
//   The pipeline has three register stages: the low limbs are handled in
//   stage one, the high limbs in stage two, and the result is selected into
//   the output register in stage three.
//   Throughput is one word per cycle while m_tready is high or a stage
//   has a bubble; stages one and two each hold one 64-bit limb slice.
//   When the receiver drops m_tready the output word is held, and the stages
//   behind it fill their bubbles before s_tready falls, so nothing is lost
//   or repeated.
//   Synchronous active-low reset on aresetn clears all valid bits; the
//   pipeline is empty and ready in the first cycle after reset.
// Depends on sma_pkg and sma_limb_unit.
`timescale 1ns / 1ps

module sign_magnitude_wide_adder
    import sma_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    // a_sign[0], a_high[64:1], a_low[128:65], b_sign[129], b_high[193:130],
    // b_low[257:194], zero padding[263:258]
    input  logic [IN_DW-1:0]  s_tdata,
    output logic              m_tvalid,
    input  logic              m_tready,
    // sum_sign[0], sum_high[64:1], sum_low[128:65], status[129],
    // zero padding[135:130]
    output logic [OUT_DW-1:0] m_tdata
);

    // Unpacked input fields.
    logic  a_sign;
    logic  b_sign;
    limb_t a_high;
    limb_t a_low;
    limb_t b_high;
    limb_t b_low;

    assign a_sign = s_tdata[0];
    assign a_high = s_tdata[64:1];
    assign a_low  = s_tdata[128:65];
    assign b_sign = s_tdata[129];
    assign b_high = s_tdata[193:130];
    assign b_low  = s_tdata[257:194];

    // Stage advance: a stage loads when it is empty or its contents move on.
    logic adv1;
    logic adv2;
    logic adv3;
    logic v1_reg, v2_reg, v3_reg;
    logic v1_next, v2_next, v3_next;

    assign adv3     = !v3_reg || m_tready;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign s_tready = adv1;

    assign v1_next = adv1 ? s_tvalid : v1_reg;
    assign v2_next = adv2 ? v1_reg   : v2_reg;
    assign v3_next = adv3 ? v2_reg   : v3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    // Stage one: low limbs.
    limb_t  lo_sum, lo_dab, lo_dba;
    carry_t lo_cout;

    sma_limb_unit u_lo (
        .x    (a_low),
        .y    (b_low),
        .cin  ('0),
        .sum  (lo_sum),
        .dxy  (lo_dab),
        .dyx  (lo_dba),
        .cout (lo_cout)
    );

    logic   as1_reg, bs1_reg;
    limb_t  ah1_reg, bh1_reg;
    limb_t  sum_lo1_reg, dab_lo1_reg, dba_lo1_reg;
    carry_t c1_reg;

    always_ff @(posedge aclk) begin
        if (adv1) begin
            as1_reg     <= a_sign;
            bs1_reg     <= b_sign;
            ah1_reg     <= a_high;
            bh1_reg     <= b_high;
            sum_lo1_reg <= lo_sum;
            dab_lo1_reg <= lo_dab;
            dba_lo1_reg <= lo_dba;
            c1_reg      <= lo_cout;
        end
    end

    // Stage two: high limbs with the carries and borrows of stage one.
    limb_t  hi_sum, hi_dab, hi_dba;
    carry_t hi_cout;

    sma_limb_unit u_hi (
        .x    (ah1_reg),
        .y    (bh1_reg),
        .cin  (c1_reg),
        .sum  (hi_sum),
        .dxy  (hi_dab),
        .dyx  (hi_dba),
        .cout (hi_cout)
    );

    logic   as2_reg, bs2_reg;
    limb_t  sum_hi2_reg, dab_hi2_reg, dba_hi2_reg;
    limb_t  sum_lo2_reg, dab_lo2_reg, dba_lo2_reg;
    carry_t c2_reg;

    always_ff @(posedge aclk) begin
        if (adv2) begin
            as2_reg     <= as1_reg;
            bs2_reg     <= bs1_reg;
            sum_hi2_reg <= hi_sum;
            dab_hi2_reg <= hi_dab;
            dba_hi2_reg <= hi_dba;
            sum_lo2_reg <= sum_lo1_reg;
            dab_lo2_reg <= dab_lo1_reg;
            dba_lo2_reg <= dba_lo1_reg;
            c2_reg      <= hi_cout;
        end
    end

    // Stage three: pick the result. A borrow out of a - b means a < b, and
    // no borrow out of either difference means the magnitudes are equal.
    logic  sign_next;
    logic  status_next;
    limb_t high_next;
    limb_t low_next;

    always_comb begin
        if (as2_reg == bs2_reg) begin
            sign_next   = as2_reg;
            high_next   = sum_hi2_reg;
            low_next    = sum_lo2_reg;
            status_next = c2_reg.sum_c;
        end else if (c2_reg.ab_b) begin
            sign_next   = bs2_reg;
            high_next   = dba_hi2_reg;
            low_next    = dba_lo2_reg;
            status_next = 1'b0;
        end else if (c2_reg.ba_b) begin
            sign_next   = as2_reg;
            high_next   = dab_hi2_reg;
            low_next    = dab_lo2_reg;
            status_next = 1'b0;
        end else begin
            sign_next   = 1'b1;
            high_next   = '0;
            low_next    = '0;
            status_next = 1'b0;
        end
    end

    logic  sign3_reg;
    logic  status3_reg;
    limb_t high3_reg;
    limb_t low3_reg;

    always_ff @(posedge aclk) begin
        if (adv3) begin
            sign3_reg   <= sign_next;
            high3_reg   <= high_next;
            low3_reg    <= low_next;
            status3_reg <= status_next;
        end
    end

    // Output word.
    assign m_tvalid = v3_reg;
    assign m_tdata  = {6'b0, status3_reg, low3_reg, high3_reg, sign3_reg};

endmodule

/* sv/sma_checker.sv */
// Port-level checker for the sign-magnitude wide adder, bound to the top level.
// Depends on sma_pkg and the macros in sign_magnitude_wide_adder_defines.svh.
`timescale 1ns / 1ps
`include "sign_magnitude_wide_adder_defines.svh"

module sma_checker
    import sma_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_tvalid,
    input logic              s_tready,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [OUT_DW-1:0] m_tdata
);

    // A stalled output word stays valid and unchanged.
    `SMA_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output word changed while stalled")

    // The pipeline is empty after reset.
    `SMA_ASSERT_RST(a_reset_empty, !aresetn, !m_tvalid, "output valid after reset")

    // A receiver that takes every word never blocks the input side.
    `SMA_ASSERT_SAME(a_ready_flow, m_tready, s_tready, "input stalled while output drains")

    // With the receiver always ready, every accepted word appears valid at the output.
    `SMA_ASSERT_NEXT(a_latency, s_tvalid && s_tready && m_tready ##1 m_tready ##1 m_tready, m_tvalid, "result missing three cycles after acceptance")

endmodule

bind sign_magnitude_wide_adder sma_checker u_sma_checker (.*);

/* dv/tb.sv */
// Self-checking testbench for the sign-magnitude wide adder.
// Drives operand pairs on the s_ stream, checks every m_ result word against a
// local signed-magnitude sum predictor. Depends on sma_pkg and the adder RTL.
`timescale 1ns / 1ps

module tb;
    import sma_pkg::*;

    // Sign and status encodings of the block.
    localparam logic SIGN_POS = 1'b1;
    localparam logic SIGN_NEG = 1'b0;
    localparam logic ST_OK    = 1'b0;
    localparam logic ST_CARRY = 1'b1;

    localparam limb_t LIMB_ONES = '1;
    localparam limb_t LIMB_ZERO = '0;
    localparam limb_t LIMB_TOP  = limb_t'(1) << (LIMB_W - 1);

    localparam int N_RANDOM    = 1750;
    localparam int CALM_TAIL   = 200;
    localparam int CYCLE_LIMIT = 200000;
    localparam int REPORT_MAX  = 10;

    typedef struct packed {
        logic  a_sign;
        limb_t a_high;
        limb_t a_low;
        logic  b_sign;
        limb_t b_high;
        limb_t b_low;
    } operand_pair_t;

    typedef struct packed {
        logic  sum_sign;
        limb_t sum_high;
        limb_t sum_low;
        logic  status;
    } sum_word_t;

    // A pending word, optionally held back until all results are in.
    typedef struct packed {
        operand_pair_t op;
        logic          drain_first;
    } pending_word_t;

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [IN_DW-1:0]  s_tdata  = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_DW-1:0] m_tdata;

    pending_word_t operand_queue[$];
    sum_word_t     sum_expect[$];
    pending_word_t tx_word;
    operand_pair_t tx_op;
    logic          in_taken  = 1'b0;
    int            s_gap     = 0;
    int            r_gap     = 0;
    int            cycles    = 0;
    int            mismatches = 0;

    sign_magnitude_wide_adder uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Signed-magnitude sum over 128-bit magnitudes with a carry flag.
    function automatic sum_word_t predict_sum(operand_pair_t op);
        sum_word_t    r;
        logic [127:0] mag_a;
        logic [127:0] mag_b;
        logic [128:0] total;
        mag_a = {op.a_high, op.a_low};
        mag_b = {op.b_high, op.b_low};
        r.status = ST_OK;
        if (op.a_sign == op.b_sign) begin
            total = {1'b0, mag_a} + {1'b0, mag_b};
            r.sum_sign = op.a_sign;
            {r.sum_high, r.sum_low} = total[127:0];
            r.status = total[128] ? ST_CARRY : ST_OK;
        end else if (mag_a == mag_b) begin
            // Cancelling operands always give a positive zero.
            r.sum_sign = SIGN_POS;
            {r.sum_high, r.sum_low} = '0;
        end else if (mag_a > mag_b) begin
            r.sum_sign = op.a_sign;
            {r.sum_high, r.sum_low} = mag_a - mag_b;
        end else begin
            r.sum_sign = op.b_sign;
            {r.sum_high, r.sum_low} = mag_b - mag_a;
        end
        return r;
    endfunction

    // Limb values biased towards the boundaries of the carry chain.
    function automatic limb_t rand_limb();
        limb_t v;
        case ($urandom_range(0, 9))
            0: v = LIMB_ZERO;
            1: v = LIMB_ONES;
            2: v = limb_t'($urandom_range(0, 15));
            3: v = LIMB_ONES - limb_t'($urandom_range(0, 15));
            4: v = limb_t'(1) << $urandom_range(0, LIMB_W - 1);
            5: v = LIMB_TOP;
            default: v = {$urandom, $urandom};
        endcase
        return v;
    endfunction

    task automatic add_pair(input logic sa, input limb_t ah, input limb_t al,
                            input logic sb, input limb_t bh, input limb_t bl,
                            input logic drain);
        pending_word_t w;
        w.op = '{a_sign: sa, a_high: ah, a_low: al, b_sign: sb, b_high: bh, b_low: bl};
        w.drain_first = drain;
        operand_queue.push_back(w);
    endtask

    // No idling in the closing stretch, and quiet windows along the way.
    function automatic logic calm_phase();
        return (operand_queue.size() < CALM_TAIL) || ((cycles % 800) >= 600);
    endfunction

    // Clock.
    initial begin
        forever #2 aclk = ~aclk;
    end

    // Cycle counter with a hard limit on the run.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Sender: present the next word once the previous one has been taken.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_taken) begin
            in_taken = 1'b0;
            if (s_gap > 0) begin
                s_gap = s_gap - 1;
                s_tvalid <= 1'b0;
            end else if (operand_queue.size() == 0) begin
                s_tvalid <= 1'b0;
            end else if (operand_queue[0].drain_first && sum_expect.size() != 0) begin
                s_tvalid <= 1'b0;
            end else if (!calm_phase() && $urandom_range(0, 5) == 0) begin
                s_gap = $urandom_range(0, 3);
                s_tvalid <= 1'b0;
            end else begin
                tx_word = operand_queue.pop_front();
                tx_op = tx_word.op;
                s_tdata <= {{(IN_DW - 258){1'b0}}, tx_op.b_low, tx_op.b_high,
                            tx_op.b_sign, tx_op.a_low, tx_op.a_high, tx_op.a_sign};
                s_tvalid <= 1'b1;
            end
        end
    end

    // Record the expected sum for every accepted operand word.
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            sum_expect.push_back(predict_sum(tx_op));
            in_taken = 1'b1;
        end
    end

    // Receiver back-pressure.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (r_gap > 0) begin
            r_gap = r_gap - 1;
            m_tready <= 1'b0;
        end else if (!calm_phase() && $urandom_range(0, 5) == 0) begin
            r_gap = $urandom_range(0, 3);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Compare each result word with the oldest outstanding sum.
    always @(posedge aclk) begin : result_check
        sum_word_t got;
        sum_word_t want;
        logic      bad;
        if (aresetn && m_tvalid && m_tready) begin
            got.sum_sign = m_tdata[0];
            got.sum_high = m_tdata[64:1];
            got.sum_low  = m_tdata[128:65];
            got.status   = m_tdata[129];
            if (sum_expect.size() == 0) begin
                if (mismatches < REPORT_MAX)
                    $display("%0t: result word with none outstanding: sign %b %h_%h st %b",
                             $realtime, got.sum_sign, got.sum_high, got.sum_low, got.status);
                mismatches++;
            end else begin
                want = sum_expect.pop_front();
                bad = (got.sum_sign !== want.sum_sign) || (got.sum_high !== want.sum_high)
                   || (got.sum_low !== want.sum_low) || (got.status !== want.status);
                if (bad) begin
                    if (mismatches < REPORT_MAX) begin
                        $display("%0t: sum mismatch", $realtime);
                        $display("  expected sign %b mag %h_%h st %b",
                                 want.sum_sign, want.sum_high, want.sum_low, want.status);
                        $display("  actual   sign %b mag %h_%h st %b",
                                 got.sum_sign, got.sum_high, got.sum_low, got.status);
                    end
                    mismatches++;
                end
            end
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        operand_pair_t op;
        int            k;

        // Directed words: zeros, extremes, cancellation and carry chains.
        add_pair(SIGN_POS, LIMB_ZERO, LIMB_ZERO, SIGN_POS, LIMB_ZERO, LIMB_ZERO, 1'b0);
        add_pair(SIGN_NEG, LIMB_ZERO, LIMB_ZERO, SIGN_NEG, LIMB_ZERO, LIMB_ZERO, 1'b0);
        add_pair(SIGN_NEG, LIMB_ZERO, LIMB_ZERO, SIGN_POS, LIMB_ZERO, LIMB_ZERO, 1'b0);
        add_pair(SIGN_POS, LIMB_ZERO, LIMB_ZERO, SIGN_NEG, LIMB_ZERO, LIMB_ZERO, 1'b0);
        add_pair(SIGN_POS, LIMB_ONES, LIMB_ONES, SIGN_POS, LIMB_ONES, LIMB_ONES, 1'b0);
        add_pair(SIGN_NEG, LIMB_ONES, LIMB_ONES, SIGN_NEG, LIMB_ZERO, 64'd1, 1'b0);
        add_pair(SIGN_POS, LIMB_ZERO, LIMB_ONES, SIGN_POS, LIMB_ZERO, 64'd1, 1'b0);
        add_pair(SIGN_POS, LIMB_ONES, LIMB_ZERO, SIGN_POS, 64'd1, LIMB_ZERO, 1'b0);
        add_pair(SIGN_NEG, LIMB_TOP, LIMB_ZERO, SIGN_NEG, LIMB_TOP, LIMB_ZERO, 1'b0);
        add_pair(SIGN_POS, LIMB_ONES, LIMB_ONES, SIGN_NEG, LIMB_ONES, LIMB_ONES, 1'b0);
        add_pair(SIGN_NEG, 64'h1234, 64'h5678, SIGN_POS, 64'h1234, 64'h5678, 1'b0);
        // Borrow across the limb boundary, both orders of magnitude.
        add_pair(SIGN_POS, 64'd1, LIMB_ZERO, SIGN_NEG, LIMB_ZERO, 64'd1, 1'b0);
        add_pair(SIGN_POS, LIMB_ZERO, 64'd1, SIGN_NEG, 64'd1, LIMB_ZERO, 1'b0);
        // Equal high limbs, the low limbs decide.
        add_pair(SIGN_NEG, LIMB_ONES, 64'd5, SIGN_POS, LIMB_ONES, 64'd3, 1'b0);
        add_pair(SIGN_NEG, LIMB_ONES, 64'd3, SIGN_POS, LIMB_ONES, 64'd5, 1'b0);
        // All-zero high limbs must not end the comparison early.
        add_pair(SIGN_POS, LIMB_ZERO, 64'd9, SIGN_NEG, LIMB_ZERO, 64'd7, 1'b0);
        add_pair(SIGN_POS, LIMB_ZERO, LIMB_ONES, SIGN_NEG, LIMB_ZERO, LIMB_ZERO, 1'b0);
        // Large against small of each sign.
        add_pair(SIGN_NEG, LIMB_ONES, LIMB_ONES, SIGN_POS, LIMB_ZERO, 64'd1, 1'b0);
        add_pair(SIGN_POS, LIMB_ZERO, 64'd1, SIGN_NEG, LIMB_ONES, LIMB_ONES, 1'b0);
        add_pair(SIGN_POS, LIMB_TOP, LIMB_ONES, SIGN_POS, LIMB_TOP, 64'd1, 1'b0);
        add_pair(SIGN_NEG, 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa,
                 SIGN_NEG, 64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555, 1'b0);

        // Random words, with magnitudes often tied to each other.
        for (k = 0; k < N_RANDOM; k++) begin
            op.a_sign = 1'($urandom_range(0, 1));
            op.b_sign = 1'($urandom_range(0, 1));
            op.a_high = rand_limb();
            op.a_low  = rand_limb();
            op.b_high = rand_limb();
            op.b_low  = rand_limb();
            case ($urandom_range(0, 9))
                0: {op.b_high, op.b_low} = {op.a_high, op.a_low};
                1: op.b_high = op.a_high;
                2: op.b_low = op.a_low;
                3: {op.b_high, op.b_low} = {op.a_high, op.a_low}
                                           + 128'($urandom_range(0, 7)) - 128'd3;
                default: ;
            endcase
            add_pair(op.a_sign, op.a_high, op.a_low, op.b_sign, op.b_high, op.b_low,
                     (k == 600 || k == 1200));
        end

        // Reset, released on a falling edge.
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Wait for every word to go in and every result to come back.
        while (operand_queue.size() != 0 || s_tvalid || sum_expect.size() != 0)
            @(negedge aclk);
        repeat (10) @(posedge aclk);

        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* files.f */
+incdir+sv
sv/sma_pkg.sv
sv/sma_limb_unit.sv
sv/sign_magnitude_wide_adder.sv
sv/sma_checker.sv
dv/tb.sv
